// File: hw/rtl/mtu_pkg.sv
`timescale 1ns / 1ps

package mtu_pkg;

    // Entry format: signed fixed point, FRAC_BITS fraction bits
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int ENTRIES     = 16;
    localparam int IDX_W       = $clog2(ENTRIES);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [PROD_W-1:0]      wide_t;

    // Saturation limits held at product width
    localparam wide_t VMAX_W = {{(PROD_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam wide_t VMIN_W = ~VMAX_W;

    // Operation codes
    localparam logic [2:0] OP_WRITE_A   = 3'd0;
    localparam logic [2:0] OP_WRITE_B   = 3'd1;
    localparam logic [2:0] OP_COMPOSE   = 3'd2;
    localparam logic [2:0] OP_ADD       = 3'd3;
    localparam logic [2:0] OP_SUB       = 3'd4;
    localparam logic [2:0] OP_SCALE     = 3'd5;
    localparam logic [2:0] OP_TRANSFORM = 3'd6;

    // Result kinds
    localparam logic RES_POINT = 1'b0;
    localparam logic RES_ENTRY = 1'b1;

    typedef struct packed {
        logic [2:0]              op;
        logic                    read_request;
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [31:0]      value;
        logic signed [31:0]      point_x;
        logic signed [31:0]      point_y;
        logic signed [31:0]      point_z;
    } s_payload_t;

    typedef struct packed {
        logic                    result_kind;
        logic signed [31:0]      out_x;
        logic signed [31:0]      out_y;
        logic signed [31:0]      out_z;
        logic signed [31:0]      entry_value;
    } m_payload_t;

    // Control of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_OPA
    } base_sel_t;

    typedef enum logic [1:0] {
        TERM_PROD,
        TERM_OPB,
        TERM_NEG_OPB
    } term_sel_t;

    typedef struct packed {
        logic      load_prod;
        logic      acc_en;
        base_sel_t base_sel;
        term_sel_t term_sel;
    } mac_ctrl_t;

    // Clamp a wide signed value to the entry range
    function automatic value_t sat_value(input wide_t x);
        value_t r;
        if (x > VMAX_W) begin
            r = VMAX_W[VALUE_WIDTH-1:0];
        end else if (x < VMIN_W) begin
            r = VMIN_W[VALUE_WIDTH-1:0];
        end else begin
            r = x[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mtu_mac.sv
`timescale 1ns / 1ps

module mtu_mac (
    input  logic              aclk,
    input  mtu_pkg::mac_ctrl_t ctrl,
    input  mtu_pkg::value_t   opa,
    input  mtu_pkg::value_t   opb,
    output mtu_pkg::value_t   sum
);
    import mtu_pkg::*;

    wide_t  prod_reg;
    value_t acc_reg;
    value_t prod_sat;
    wide_t  base_w;
    wide_t  term_w;

    // Register the full product and, when enabled, the accumulated sum
    always_ff @(posedge aclk) begin
        if (ctrl.load_prod) begin
            prod_reg <= wide_t'(opa) * wide_t'(opb);
        end
        if (ctrl.acc_en) begin
            acc_reg <= sum;
        end
    end

    // Drop fraction bits (floor) and clamp the product
    assign prod_sat = sat_value(prod_reg >>> FRAC_BITS);

    // Select addend sources
    always_comb begin
        case (ctrl.base_sel)
            BASE_ACC: base_w = wide_t'(acc_reg);
            BASE_OPA: base_w = wide_t'(opa);
            default:  base_w = '0;
        endcase
        case (ctrl.term_sel)
            TERM_OPB:     term_w = wide_t'(opb);
            TERM_NEG_OPB: term_w = -wide_t'(opb);
            default:      term_w = wide_t'(prod_sat);
        endcase
    end

    // Saturating add
    assign sum = sat_value(base_w + term_w);

endmodule

// File: hw/rtl/matrix4_transform_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    mtu_pkg::s_payload_t (one request)
// m_       out        m_valid/m_ready    mtu_pkg::m_payload_t (zero or one result)
//
// Requests are taken only in the idle state, so a new request waits until the
// previous one is done. One shared multiplier and saturating adder serve all
// operations; each multiply-accumulate passes through a multiply state (ST_MUL)
// and then an accumulate state (ST_ACC).
// Synchronous active-low reset clears both matrices, the state and the output valid flag.
// A held result stalls only a request that itself produces a result.

module matrix4_transform_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mtu_pkg::s_payload_t  s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mtu_pkg::m_payload_t  m_payload
);
    import mtu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDSUB,
        ST_MUL,
        ST_ACC,
        ST_ROWWB,
        ST_OFFSET,
        ST_RESP
    } state_t;

    state_t          state_reg;
    value_t          matrix_a_reg [ENTRIES];
    value_t          matrix_b_reg [ENTRIES];
    value_t          row_buf_reg [4];
    logic [2:0]      op_reg;
    value_t          scale_reg;
    value_t          pt_x_reg;
    value_t          pt_y_reg;
    value_t          pt_z_reg;
    logic [IDX_W-1:0] ent_reg;
    logic [1:0]      k_reg;
    logic            res_kind_reg;
    value_t          res_x_reg;
    value_t          res_y_reg;
    value_t          res_z_reg;
    value_t          res_entry_reg;
    logic            m_valid_reg;
    m_payload_t      m_payload_reg;

    mac_ctrl_t       mac_ctrl;
    value_t          opa;
    value_t          opb;
    value_t          mac_sum;
    logic [1:0]      row_i;
    logic [1:0]      col_j;
    logic [1:0]      wb_row;
    logic [IDX_W-1:0] s_idx;

    assign row_i   = ent_reg[3:2];
    assign col_j   = ent_reg[1:0];
    assign wb_row  = row_i - 2'd1;
    assign s_idx   = {s_payload.row, s_payload.col};
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_payload = m_payload_reg;

    mtu_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .opa  (opa),
        .opb  (opb),
        .sum  (mac_sum)
    );

    // Steer operands and control to the shared unit
    always_comb begin
        opa      = '0;
        opb      = '0;
        mac_ctrl = '{load_prod: 1'b0, acc_en: 1'b0, base_sel: BASE_ZERO,
                     term_sel: TERM_PROD};
        case (state_reg)
            ST_ADDSUB: begin
                opa = matrix_a_reg[ent_reg];
                opb = matrix_b_reg[ent_reg];
                mac_ctrl.base_sel = BASE_OPA;
                mac_ctrl.term_sel = (op_reg == OP_SUB) ? TERM_NEG_OPB : TERM_OPB;
            end
            ST_MUL: begin
                mac_ctrl.load_prod = 1'b1;
                if (op_reg == OP_SCALE) begin
                    opa = matrix_a_reg[ent_reg];
                    opb = scale_reg;
                end else if (op_reg == OP_COMPOSE) begin
                    opa = matrix_a_reg[{row_i, k_reg}];
                    opb = matrix_b_reg[{k_reg, col_j}];
                end else begin
                    opa = matrix_a_reg[{row_i, k_reg}];
                    case (k_reg)
                        2'd0:    opb = pt_x_reg;
                        2'd1:    opb = pt_y_reg;
                        default: opb = pt_z_reg;
                    endcase
                end
            end
            ST_ACC: begin
                mac_ctrl.acc_en   = 1'b1;
                mac_ctrl.term_sel = TERM_PROD;
                mac_ctrl.base_sel = (op_reg == OP_SCALE || k_reg == 2'd0) ?
                                    BASE_ZERO : BASE_ACC;
            end
            ST_OFFSET: begin
                opb = matrix_a_reg[{row_i, 2'd3}];
                mac_ctrl.base_sel = BASE_ACC;
                mac_ctrl.term_sel = TERM_OPB;
            end
            default: begin
                opa = '0;
            end
        endcase
    end

    // Sequencer, matrices and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                matrix_a_reg[e] <= '0;
                matrix_b_reg[e] <= '0;
            end
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_payload.op;
                        scale_reg <= s_payload.value;
                        pt_x_reg  <= s_payload.point_x;
                        pt_y_reg  <= s_payload.point_y;
                        pt_z_reg  <= s_payload.point_z;
                        ent_reg   <= '0;
                        k_reg     <= 2'd0;
                        case (s_payload.op)
                            OP_WRITE_A: begin
                                if (s_payload.read_request) begin
                                    res_kind_reg  <= RES_ENTRY;
                                    res_x_reg     <= '0;
                                    res_y_reg     <= '0;
                                    res_z_reg     <= '0;
                                    res_entry_reg <= matrix_a_reg[s_idx];
                                    state_reg     <= ST_RESP;
                                end else begin
                                    matrix_a_reg[s_idx] <= s_payload.value;
                                end
                            end
                            OP_WRITE_B: begin
                                matrix_b_reg[s_idx] <= s_payload.value;
                            end
                            OP_ADD, OP_SUB: begin
                                state_reg <= ST_ADDSUB;
                            end
                            OP_COMPOSE, OP_SCALE, OP_TRANSFORM: begin
                                state_reg <= ST_MUL;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_ADDSUB: begin
                    matrix_a_reg[ent_reg] <= mac_sum;
                    ent_reg <= ent_reg + 4'd1;
                    if (&ent_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    case (op_reg)
                        OP_SCALE: begin
                            matrix_a_reg[ent_reg] <= mac_sum;
                            ent_reg   <= ent_reg + 4'd1;
                            state_reg <= (&ent_reg) ? ST_IDLE : ST_MUL;
                        end
                        OP_COMPOSE: begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_MUL;
                            if (k_reg == 2'd3) begin
                                row_buf_reg[col_j] <= mac_sum;
                                ent_reg <= ent_reg + 4'd1;
                                if (col_j == 2'd3) begin
                                    state_reg <= ST_ROWWB;
                                end
                            end
                        end
                        OP_TRANSFORM: begin
                            if (k_reg == 2'd2) begin
                                k_reg     <= 2'd0;
                                state_reg <= ST_OFFSET;
                            end else begin
                                k_reg     <= k_reg + 2'd1;
                                state_reg <= ST_MUL;
                            end
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_ROWWB: begin
                    // Commit a finished product row; later rows never read it
                    for (int c = 0; c < 4; c++) begin
                        matrix_a_reg[{wb_row, 2'(c)}] <= row_buf_reg[c];
                    end
                    state_reg <= (wb_row == 2'd3) ? ST_IDLE : ST_MUL;
                end
                ST_OFFSET: begin
                    case (row_i)
                        2'd0:    res_x_reg <= mac_sum;
                        2'd1:    res_y_reg <= mac_sum;
                        default: res_z_reg <= mac_sum;
                    endcase
                    ent_reg <= ent_reg + 4'd4;
                    if (row_i == 2'd2) begin
                        res_kind_reg  <= RES_POINT;
                        res_entry_reg <= '0;
                        state_reg     <= ST_RESP;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_RESP: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_payload_reg <= '{result_kind: res_kind_reg,
                                           out_x:       res_x_reg,
                                           out_y:       res_y_reg,
                                           out_z:       res_z_reg,
                                           entry_value: res_entry_reg};
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
